// File: hdl/sfct_pkg.sv
// Shared constants, types and CRC helper for the stuffed-frame CRC transmitter.
`default_nettype none
package sfct_pkg;

	localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
	localparam logic [7:0]  ESC_BYTE   = 8'h7D;
	localparam logic [7:0]  ESC_XOR    = 8'h20;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] POLY_RESET = 16'h8408;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	localparam int  RUN_DEPTH = 6;
	localparam int  RUN_IDX_W = $clog2(RUN_DEPTH);
	localparam int  RUN_CNT_W = $clog2(RUN_DEPTH + 1);

	// APB register map, byte addresses
	localparam logic [1:0] ADDR_CRC_POLY = 2'd0;

	// bytes caused by one input item, sent in slot order
	typedef struct packed {
		logic [RUN_DEPTH-1:0][7:0] bytes;
		logic [RUN_CNT_W-1:0]      cnt;
	} run_t;

	// reflected CRC, LSB first, one byte
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] d,
	                                         input logic [15:0] poly);
		logic [15:0] c;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[k]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: hdl/sfct_encoder.sv
// Framing engine: packet state, CRC update and byte stuffing for one item.
`default_nettype none
module sfct_encoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        op,
	input  wire logic [7:0]  tag,
	input  wire logic [15:0] tag_crc,
	input  wire logic [7:0]  length,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] poly,
	output sfct_pkg::run_t   run
);

	logic [15:0] crc_q;
	logic [7:0]  rem_q;
	logic        open_q;

	logic [15:0] crc_d;
	logic [7:0]  rem_d;
	logic        open_d;

	logic [15:0] fold;
	logic [15:0] inv;
	logic        esc;
	logic        closing;

	// start items fold length on top of the tag CRC taken at the input
	assign fold    = sfct_pkg::crc_fold((op == sfct_pkg::OP_START) ? tag_crc : crc_q,
	                                    (op == sfct_pkg::OP_START) ? length : data_byte, poly);
	assign inv     = ~fold;
	assign esc     = (data_byte == sfct_pkg::FLAG_BYTE) || (data_byte == sfct_pkg::ESC_BYTE);
	assign closing = (rem_q == 8'd1);

	always_comb begin
		run    = '0;
		crc_d  = crc_q;
		rem_d  = rem_q;
		open_d = open_q;
		if (op == sfct_pkg::OP_START) begin
			run.bytes[0] = sfct_pkg::FLAG_BYTE;
			run.bytes[1] = tag;
			run.bytes[2] = length;
			if (length == 8'd0) begin
				// empty packet: zero CRC bytes and close at once
				run.bytes[3] = 8'h00;
				run.bytes[4] = 8'h00;
				run.bytes[5] = sfct_pkg::FLAG_BYTE;
				run.cnt      = sfct_pkg::RUN_CNT_W'(6);
				crc_d        = sfct_pkg::CRC_INIT;
				rem_d        = 8'd0;
				open_d       = 1'b0;
			end else begin
				run.cnt = sfct_pkg::RUN_CNT_W'(3);
				crc_d   = fold;
				rem_d   = length;
				open_d  = 1'b1;
			end
		end else if (open_q) begin
			rem_d = rem_q - 8'd1;
			crc_d = fold;
			if (esc) begin
				run.bytes[0] = sfct_pkg::ESC_BYTE;
				run.bytes[1] = data_byte ^ sfct_pkg::ESC_XOR;
				run.cnt      = sfct_pkg::RUN_CNT_W'(2);
				if (closing) begin
					run.bytes[2] = inv[7:0];
					run.bytes[3] = inv[15:8];
					run.bytes[4] = sfct_pkg::FLAG_BYTE;
					run.cnt      = sfct_pkg::RUN_CNT_W'(5);
				end
			end else begin
				run.bytes[0] = data_byte;
				run.cnt      = sfct_pkg::RUN_CNT_W'(1);
				if (closing) begin
					run.bytes[1] = inv[7:0];
					run.bytes[2] = inv[15:8];
					run.bytes[3] = sfct_pkg::FLAG_BYTE;
					run.cnt      = sfct_pkg::RUN_CNT_W'(4);
				end
			end
			if (closing) begin
				crc_d  = sfct_pkg::CRC_INIT;
				open_d = 1'b0;
			end
		end
		// data with no open packet: empty run, state untouched
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= sfct_pkg::CRC_INIT;
			rem_q  <= 8'd0;
			open_q <= 1'b0;
		end else if (step) begin
			crc_q  <= crc_d;
			rem_q  <= rem_d;
			open_q <= open_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/stuffed_frame_crc_transmitter_unit.sv
// Top level of the stuffed-frame CRC transmitter: input register, encoder, byte serializer.
// Usage:
//   Input channel (in_valid/in_ready) takes one item per beat: operation 0 opens a
//   packet with tag and length, operation 1 carries one payload byte. Output channel
//   (out_valid/out_ready) sends the framed line stream one byte per beat; run_last
//   marks the last byte caused by an item.
//   APB port: register 0 at address 0 is the reflected CRC polynomial (bits 15:0).
//   Write it only while the block is idle.
// Path: an item passes the input register and then the run register before its first byte is valid;
// Throughput: one line byte per cycle while out_ready is high. An item holds the serializer
//   until the last of the bytes it causes (1 to 6; an escaped byte costs 2) is taken. The input register
//   takes the next item while the serializer still drains the previous run, so
//   items flow back to back; a payload byte with no open packet passes through
//   the input register and yields nothing.
// Reset: no packet open, CRC accumulator 0xFFFF, polynomial 0x8408.
// Stall: while out_ready is low the current byte holds; once the input register
//   is full, in_ready drops until the serializer takes its run.
`default_nettype none
module stuffed_frame_crc_transmitter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [7:0]  tag,
	input  wire logic [7:0]  length,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       line_byte,
	output logic             run_last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0] poly_q;

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  tag_s1;
	logic [7:0]  len_s1;
	logic [7:0]  db_s1;
	logic [15:0] tag_crc_s1;

	sfct_pkg::run_t run;

	logic                                 run_valid_q;
	logic [sfct_pkg::RUN_DEPTH-1:0][7:0] run_bytes_q;
	logic [sfct_pkg::RUN_CNT_W-1:0]      run_cnt_q;
	logic [sfct_pkg::RUN_IDX_W-1:0]      idx_q;

	logic out_fire;
	logic at_last;
	logic s1_move;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == sfct_pkg::ADDR_CRC_POLY) ? {16'h0000, poly_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= sfct_pkg::POLY_RESET;
		end else if (psel && penable && pwrite && pready) begin
			poly_q <= pwdata[15:0];
		end
	end

	// serializer handshake
	assign out_valid = run_valid_q;
	assign line_byte = run_bytes_q[idx_q];
	assign at_last   = (idx_q == sfct_pkg::RUN_IDX_W'(run_cnt_q - sfct_pkg::RUN_CNT_W'(1)));
	assign run_last  = at_last;
	assign out_fire  = out_valid && out_ready;
	assign s1_move   = valid_s1 && (!run_valid_q || (out_fire && at_last));
	assign in_ready  = !valid_s1 || s1_move;

	// input register; tag CRC is seeded here so the encoder folds one byte only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= operation;
			tag_s1     <= tag;
			len_s1     <= length;
			db_s1      <= data_byte;
			tag_crc_s1 <= sfct_pkg::crc_fold(sfct_pkg::CRC_INIT, tag, poly_q);
		end
	end

	sfct_encoder u_encoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_move),
		.op        (op_s1),
		.tag       (tag_s1),
		.tag_crc   (tag_crc_s1),
		.length    (len_s1),
		.data_byte (db_s1),
		.poly      (poly_q),
		.run       (run)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (s1_move) begin
			run_valid_q <= (run.cnt != '0);
			idx_q       <= '0;
		end else if (out_fire) begin
			if (at_last) begin
				run_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + sfct_pkg::RUN_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			run_bytes_q <= run.bytes;
			run_cnt_q   <= run.cnt;
		end
	end

endmodule
`default_nettype wire

// File: bench/tb.sv
// Testbench for stuffed_frame_crc_transmitter_unit: framing, byte stuffing and CRC checks.
`timescale 1ns / 100ps
module tb;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
	} line_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        operation = sfct_pkg::OP_START;
	logic [7:0]  tag = 8'h00;
	logic [7:0]  length = 8'h00;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  line_byte;
	logic        run_last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = sfct_pkg::ADDR_CRC_POLY;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state
	logic [15:0] crc_poly_now = sfct_pkg::POLY_RESET;
	logic [15:0] crc_running = sfct_pkg::CRC_INIT;
	logic [7:0]  bytes_left = 8'd0;
	logic        frame_open = 1'b0;
	line_beat_t  line_beats_due[$];

	line_beat_t  beat_want;
	int          fail_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          stall_left = 0;

	stuffed_frame_crc_transmitter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .tag(tag), .length(length), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.line_byte(line_byte), .run_last(run_last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("stuffed_frame_crc_transmitter_unit test failed");
		$finish;
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// reflected CRC, one byte folded in LSB first
	function automatic logic [15:0] crc_shift_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {8'h00, d};
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ crc_poly_now) : (c >> 1);
		end
		return c;
	endfunction

	// bytes on the line caused by one accepted item
	task automatic frame_item(input logic op, input logic [7:0] t, input logic [7:0] l,
	                          input logic [7:0] d);
		logic [7:0]  run_bytes[$];
		logic [15:0] fcs;
		line_beat_t  b;
		if (op == sfct_pkg::OP_START) begin
			run_bytes.push_back(sfct_pkg::FLAG_BYTE);
			run_bytes.push_back(t);
			run_bytes.push_back(l);
			if (l == 8'd0) begin
				run_bytes.push_back(8'h00);
				run_bytes.push_back(8'h00);
				run_bytes.push_back(sfct_pkg::FLAG_BYTE);
				crc_running = sfct_pkg::CRC_INIT;
				bytes_left = 8'd0;
				frame_open = 1'b0;
			end else begin
				crc_running = crc_shift_byte(crc_shift_byte(sfct_pkg::CRC_INIT, t), l);
				bytes_left = l;
				frame_open = 1'b1;
			end
		end else if (frame_open) begin
			crc_running = crc_shift_byte(crc_running, d);
			if (d == sfct_pkg::FLAG_BYTE || d == sfct_pkg::ESC_BYTE) begin
				run_bytes.push_back(sfct_pkg::ESC_BYTE);
				run_bytes.push_back(d ^ sfct_pkg::ESC_XOR);
			end else begin
				run_bytes.push_back(d);
			end
			bytes_left = bytes_left - 8'd1;
			if (bytes_left == 8'd0) begin
				fcs = ~crc_running;
				run_bytes.push_back(fcs[7:0]);
				run_bytes.push_back(fcs[15:8]);
				run_bytes.push_back(sfct_pkg::FLAG_BYTE);
				crc_running = sfct_pkg::CRC_INIT;
				frame_open = 1'b0;
			end
		end
		foreach (run_bytes[i]) begin
			b.line_byte = run_bytes[i];
			b.run_last = (i == run_bytes.size() - 1);
			line_beats_due.push_back(b);
		end
	endtask

	// called at a rising edge; returns at the edge where the beat is taken
	task automatic send_item(input logic op, input logic [7:0] t, input logic [7:0] l,
	                         input logic [7:0] d);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		tag <= t;
		length <= l;
		data_byte <= d;
		do @(posedge clk); while (!in_ready);
		frame_item(op, t, l, d);
	endtask

	// stop offering, wait out all due beats, then let the block sit quiet for a while
	task automatic settle();
		in_valid <= 1'b0;
		while (line_beats_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_crc_poly(input logic [15:0] value);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sfct_pkg::ADDR_CRC_POLY;
		pwdata <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		crc_poly_now = value;
		// read back, second transfer follows directly
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {16'h0000, value}) begin
			note_failure($sformatf("crc_polynomial readback: expected %h actual %h",
				{16'h0000, value}, prdata));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] rand_payload();
		int r;
		r = $urandom_range(99);
		if (r < 12) begin
			return sfct_pkg::FLAG_BYTE;
		end else if (r < 24) begin
			return sfct_pkg::ESC_BYTE;
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] rand_length();
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			return 8'd0;
		end else if (r < 85) begin
			return 8'($urandom_range(1, 8));
		end
		return 8'($urandom_range(9, 40));
	endfunction

	task automatic send_frame(input logic [7:0] t, input logic [7:0] l);
		send_item(sfct_pkg::OP_START, t, l, 8'($urandom_range(255)));
		repeat (l) begin
			send_item(sfct_pkg::OP_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
				rand_payload());
		end
	endtask

	// receiver: random stalls plus a counted hold-off on request
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (line_beats_due.size() == 0) begin
				note_failure($sformatf("unexpected beat: line_byte %h run_last %b",
					line_byte, run_last));
			end else begin
				beat_want = line_beats_due.pop_front();
				if (line_byte !== beat_want.line_byte) begin
					note_failure($sformatf("line_byte: expected %h actual %h",
						beat_want.line_byte, line_byte));
				end
				if (run_last !== beat_want.run_last) begin
					note_failure($sformatf("run_last: expected %b actual %b (byte %h)",
						beat_want.run_last, run_last, beat_want.line_byte));
				end
			end
		end
	end

	task automatic test_framing_basics();
		// payload with no frame open is dropped
		send_item(sfct_pkg::OP_DATA, 8'hFF, 8'hFF, 8'h7E);
		// empty frame
		send_item(sfct_pkg::OP_START, 8'h00, 8'h00, 8'hFF);
		// frame abandoned by a new start
		send_item(sfct_pkg::OP_START, 8'hFF, 8'hFF, 8'hFF);
		send_item(sfct_pkg::OP_DATA, 8'h00, 8'h00, 8'h7E);
		send_item(sfct_pkg::OP_START, 8'h5A, 8'h05, 8'h00);
		send_item(sfct_pkg::OP_DATA, 8'hFF, 8'hFF, 8'h7E);
		send_item(sfct_pkg::OP_DATA, 8'h00, 8'h00, 8'h7D);
		send_item(sfct_pkg::OP_DATA, 8'hFF, 8'hFF, 8'h00);
		send_item(sfct_pkg::OP_DATA, 8'h00, 8'h00, 8'hFF);
		send_item(sfct_pkg::OP_DATA, 8'hFF, 8'hFF, 8'h5E);
		send_item(sfct_pkg::OP_DATA, 8'h12, 8'h34, 8'h55);
		// single escaped byte then trailer: longest run a payload byte can cause
		send_item(sfct_pkg::OP_START, 8'hA5, 8'h01, 8'h00);
		send_item(sfct_pkg::OP_DATA, 8'h00, 8'h00, 8'h7D);
		// flag and escape values in header go out as is
		send_item(sfct_pkg::OP_START, 8'h7E, 8'h02, 8'h7E);
		send_item(sfct_pkg::OP_DATA, 8'h00, 8'h00, 8'h20);
		send_item(sfct_pkg::OP_DATA, 8'h00, 8'h00, 8'h5D);
		send_item(sfct_pkg::OP_START, 8'h7D, 8'h00, 8'h7D);
	endtask

	task automatic test_poly_extremes();
		set_crc_poly(16'h0000);
		send_frame(8'h3C, 8'd3);
		set_crc_poly(16'hFFFF);
		send_item(sfct_pkg::OP_START, 8'hC3, 8'd2, 8'h00);
		send_item(sfct_pkg::OP_DATA, 8'h00, 8'h00, 8'h7E);
		send_item(sfct_pkg::OP_DATA, 8'h00, 8'h00, 8'hFF);
		set_crc_poly(sfct_pkg::POLY_RESET);
	endtask

	task automatic test_output_stall();
		int saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		stall_left = 80;
		send_frame(8'($urandom_range(255)), 8'd6);
		send_frame(8'($urandom_range(255)), 8'd4);
		send_frame(8'($urandom_range(255)), 8'd0);
		send_frame(8'($urandom_range(255)), 8'd5);
		send_idle_pct = saved_pct;
		settle();
	endtask

	task automatic test_random_traffic(input logic [15:0] poly, input int budget);
		int sent;
		int r;
		int cut;
		logic [7:0] l;
		set_crc_poly(poly);
		sent = 0;
		while (sent < budget) begin
			r = $urandom_range(99);
			if (r < 8 && !frame_open) begin
				// stray payload, dropped by the block
				send_item(sfct_pkg::OP_DATA, 8'($urandom_range(255)),
					8'($urandom_range(255)), rand_payload());
			end else if (r < 20) begin
				// frame cut short, next start abandons it
				l = 8'($urandom_range(255));
				cut = (l == 8'd0) ? 0 : $urandom_range(0, (l < 4) ? l - 1 : 3);
				send_item(sfct_pkg::OP_START, 8'($urandom_range(255)), l,
					8'($urandom_range(255)));
				repeat (cut) begin
					send_item(sfct_pkg::OP_DATA, 8'($urandom_range(255)),
						8'($urandom_range(255)), rand_payload());
				end
				sent += 1 + cut;
			end else begin
				l = rand_length();
				send_frame(8'($urandom_range(255)), l);
				sent += 1 + l;
			end
		end
		if (frame_open) begin
			send_item(sfct_pkg::OP_START, 8'($urandom_range(255)), 8'd0,
				8'($urandom_range(255)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 33;
		recv_idle_pct = 56;
		test_framing_basics();
		test_poly_extremes();
		test_output_stall();
		test_random_traffic(16'hA001, 70);
		send_idle_pct = 56;
		recv_idle_pct = 33;
		test_random_traffic(16'($urandom_range(65535)), 70);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(sfct_pkg::POLY_RESET, 70);
		settle();
		if (fail_count == 0) begin
			$display("stuffed_frame_crc_transmitter_unit test passed");
		end else begin
			$display("stuffed_frame_crc_transmitter_unit test failed");
		end
		$finish;
	end

endmodule
